// File: src/bsf_pkg.sv
// Shared types and constants for the band spectral flux block.
// Used by bsf_divider and band_spectral_flux; depends on nothing else.
`timescale 1ns / 1ps

package bsf_pkg;

    // Field and state widths.
    localparam int MAG_W  = 16;
    localparam int BIN_W  = 9;
    localparam int SUM_W  = 25;
    localparam int FLUX_W = 16;
    localparam int DIV_W  = BIN_W + 1;
    localparam int CNT_W  = $clog2(SUM_W);

    // Register reset values.
    localparam logic [BIN_W-1:0] START_BIN_RESET = 9'd1;
    localparam logic [BIN_W-1:0] END_BIN_RESET   = 9'd5;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        REG_START_BIN = 1'b0,
        REG_END_BIN   = 1'b1
    } cfg_idx_t;

    // Request to the end-of-frame divider.
    typedef struct packed {
        logic             start;
        logic             band_ok;
        logic [SUM_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } div_req_t;

    // Status returned by the divider.
    typedef struct packed {
        logic              busy;
        logic              done;
        logic [FLUX_W-1:0] quotient;
    } div_stat_t;

endpackage

// File: src/bsf_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; holds the previous spectrum of the band spectral flux block.
`timescale 1ns / 1ps

module bsf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Read returns the old contents when the same entry is written in that cycle.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: src/bsf_divider.sv
// Restoring divider, one quotient bit per cycle, for the end-of-frame mean.
// Depends on bsf_pkg for widths and the request and status structs.
`timescale 1ns / 1ps

module bsf_divider (
    input  logic               aclk,
    input  logic               aresetn,
    input  bsf_pkg::div_req_t  req,
    output bsf_pkg::div_stat_t stat
);

    import bsf_pkg::*;

    logic             busy_reg, busy_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [SUM_W-1:0] quo_reg, quo_next;
    logic [DIV_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0] den_reg, den_next;
    logic [DIV_W:0]   rem_shift;
    logic             last_step;

    assign rem_shift = {rem_reg, quo_reg[SUM_W-1]};
    assign last_step = (cnt_reg == CNT_W'(SUM_W - 1));

    // One shift-and-subtract step per cycle; an empty band divides zero by one.
    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (busy_reg) begin
            if (rem_shift >= {1'b0, den_reg}) begin
                rem_next = DIV_W'(rem_shift - {1'b0, den_reg});
                quo_next = {quo_reg[SUM_W-2:0], 1'b1};
            end else begin
                rem_next = rem_shift[DIV_W-1:0];
                quo_next = {quo_reg[SUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (last_step) begin
                busy_next = 1'b0;
            end
        end else if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = req.band_ok ? req.dividend : '0;
            den_next  = req.band_ok ? req.divisor : DIV_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    // The quotient is valid in the cycle of the final step.
    assign stat.busy     = busy_reg;
    assign stat.done     = busy_reg && last_step;
    assign stat.quotient = quo_next[FLUX_W-1:0];

endmodule

// File: src/band_spectral_flux.sv
// Band-limited spectral flux: one bin magnitude per request on s_axis, one
// mean rise per frame on m_axis. Depends on bsf_pkg, bsf_ram and bsf_divider.
//
// A non-final bin is taken every cycle in normal operation; its magnitude is
// read from the previous-spectrum RAM, compared and written back in the cycle
// after, with forwarding covering a read of the entry the bin ahead writes.
// The final bin of a frame starts a one-bit-per-cycle divider whose quotient
// is registered at the output; a further final bin is held off until the
// previous result has been delivered, while the bins of the next frame keep
// flowing. After reset a clearing pass zeroes all FRAME_BINS RAM entries and
// takes no bin meanwhile; configuration writes are taken at any time.
`timescale 1ns / 1ps

module band_spectral_flux #(
    parameter int FRAME_BINS = 512
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // Configuration write port.
    input  logic                         cfg_we,
    input  bsf_pkg::cfg_idx_t            cfg_addr,
    input  logic [bsf_pkg::BIN_W-1:0]    cfg_wdata,
    // Bin input.
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [bsf_pkg::MAG_W-1:0]    s_axis_tdata,   // [15:0] magnitude
    input  logic                         s_axis_tlast,   // last_bin
    // Flux output.
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [bsf_pkg::FLUX_W-1:0]   m_axis_tdata    // [15:0] flux
);

    import bsf_pkg::*;

    localparam int ADDR_W = $clog2(FRAME_BINS);
    localparam int POS_W  = $clog2(FRAME_BINS + 1);
    localparam int CMP_W  = (POS_W > BIN_W) ? POS_W : BIN_W;

    typedef enum logic [1:0] {
        ST_CLEAR = 2'b01,
        ST_RUN   = 2'b10
    } state_t;

    state_t             state_reg, state_next;
    logic [ADDR_W-1:0]  clr_addr_reg, clr_addr_next;

    logic [BIN_W-1:0]   start_bin_reg, start_bin_next;
    logic [BIN_W-1:0]   end_bin_reg, end_bin_next;

    logic [POS_W-1:0]   bin_pos_reg, bin_pos_next;
    logic [SUM_W-1:0]   rise_sum_reg, rise_sum_next;

    logic               s1_valid_reg, s1_valid_next;
    logic               s1_last_reg;
    logic               s1_inrange_reg;
    logic               s1_inband_reg;
    logic [ADDR_W-1:0]  s1_addr_reg;
    logic [MAG_W-1:0]   s1_mag_reg;

    logic               fwd_valid_reg, fwd_valid_next;
    logic [MAG_W-1:0]   fwd_data_reg;

    logic               m_valid_reg, m_valid_next;
    logic [FLUX_W-1:0]  m_data_reg, m_data_next;

    logic               accept;
    logic               in_range;
    logic               in_band;
    logic               band_ok;
    logic               end_pending;
    logic [CMP_W-1:0]   pos_cmp;
    logic [ADDR_W-1:0]  rd_addr;
    logic [MAG_W-1:0]   rd_data;
    logic [MAG_W-1:0]   old_mag;
    logic [MAG_W-1:0]   rise;
    logic [SUM_W-1:0]   sum_with_rise;
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [MAG_W-1:0]   ram_wdata;

    div_req_t           div_req;
    div_stat_t          div_stat;

    // Configuration registers.
    always_comb begin
        start_bin_next = start_bin_reg;
        end_bin_next   = end_bin_reg;
        if (cfg_we) begin
            unique case (cfg_addr)
                REG_START_BIN: start_bin_next = cfg_wdata;
                REG_END_BIN:   end_bin_next   = cfg_wdata;
                default:       ;
            endcase
        end
    end

    assign band_ok = (start_bin_reg <= end_bin_reg);

    // A final bin waits while the previous frame's result is still in flight.
    assign end_pending   = (s1_valid_reg && s1_last_reg) || div_stat.busy || m_valid_reg;
    assign s_axis_tready = (state_reg == ST_RUN) && (!s_axis_tlast || !end_pending);
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Bin position and band membership of the incoming bin.
    assign in_range = (bin_pos_reg < POS_W'(FRAME_BINS));
    assign pos_cmp  = CMP_W'(bin_pos_reg);
    assign in_band  = band_ok && (pos_cmp >= CMP_W'(start_bin_reg))
                      && (pos_cmp <= CMP_W'(end_bin_reg));
    assign rd_addr  = bin_pos_reg[ADDR_W-1:0];

    always_comb begin
        bin_pos_next = bin_pos_reg;
        if (accept) begin
            if (s_axis_tlast) begin
                bin_pos_next = '0;
            end else if (in_range) begin
                bin_pos_next = bin_pos_reg + 1'b1;
            end
        end
    end

    // Clearing pass after reset, then normal operation.
    always_comb begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == ADDR_W'(FRAME_BINS - 1)) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: ;
            default: state_next = ST_CLEAR;
        endcase
    end

    // Forward the write of the bin ahead when the next read hits the same entry.
    assign s1_valid_next  = accept;
    assign fwd_valid_next = s1_valid_reg && s1_inrange_reg && accept && in_range
                            && (rd_addr == s1_addr_reg);
    assign old_mag        = fwd_valid_reg ? fwd_data_reg : rd_data;

    // Positive rise over the previous frame and the running sum.
    assign rise          = (s1_inband_reg && (s1_mag_reg > old_mag)) ?
                           MAG_W'(s1_mag_reg - old_mag) : '0;
    assign sum_with_rise = SUM_W'(rise_sum_reg + SUM_W'(rise));

    always_comb begin
        rise_sum_next = rise_sum_reg;
        if (s1_valid_reg) begin
            rise_sum_next = s1_last_reg ? '0 : sum_with_rise;
        end
    end

    // Divider start on the final bin of a frame.
    assign div_req.start    = s1_valid_reg && s1_last_reg;
    assign div_req.band_ok  = band_ok;
    assign div_req.dividend = sum_with_rise;
    assign div_req.divisor  = DIV_W'({1'b0, end_bin_reg} - {1'b0, start_bin_reg} + 1'b1);

    bsf_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .stat    (div_stat)
    );

    // RAM write port: zeros during the clearing pass, then the stage-one bin.
    always_comb begin
        if (state_reg == ST_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_reg;
            ram_wdata = '0;
        end else begin
            ram_we    = s1_valid_reg && s1_inrange_reg;
            ram_waddr = s1_addr_reg;
            ram_wdata = s1_mag_reg;
        end
    end

    bsf_ram #(
        .WIDTH (MAG_W),
        .DEPTH (FRAME_BINS)
    ) u_prev (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // Output register.
    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (m_valid_reg && m_axis_tready) begin
            m_valid_next = 1'b0;
        end
        if (div_stat.done) begin
            m_valid_next = 1'b1;
            m_data_next  = div_stat.quotient;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            start_bin_reg <= START_BIN_RESET;
            end_bin_reg   <= END_BIN_RESET;
            bin_pos_reg   <= '0;
            rise_sum_reg  <= '0;
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            start_bin_reg <= start_bin_next;
            end_bin_reg   <= end_bin_next;
            bin_pos_reg   <= bin_pos_next;
            rise_sum_reg  <= rise_sum_next;
            s1_valid_reg  <= s1_valid_next;
            fwd_valid_reg <= fwd_valid_next;
            m_valid_reg   <= m_valid_next;
        end
        m_data_reg   <= m_data_next;
        fwd_data_reg <= s1_mag_reg;
        if (accept) begin
            s1_last_reg    <= s_axis_tlast;
            s1_inrange_reg <= in_range;
            s1_inband_reg  <= in_range && in_band;
            s1_addr_reg    <= rd_addr;
            s1_mag_reg     <= s_axis_tdata;
        end
    end

endmodule
